// ===== rtl/core/bss_pkg.sv =====
// Package for the four-digit seven-segment scan block.
// Holds the shift-add-3 payload type, its step function and the segment table.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package bss_pkg;

    // Binary input width and the number of BCD digits the conversion needs.
    localparam int BIN_W      = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Digits shown on the display, segment byte width and stream widths.
    localparam int SHOW_DIGITS = 4;
    localparam int SEG_W       = 8;
    localparam int POS_W       = 2;
    localparam int TDATA_W     = 16;

    // Conversion steps per pipeline stage; they add up to BIN_W.
    localparam int STEPS_S0 = 6;
    localparam int STEPS_S1 = 5;
    localparam int STEPS_S2 = 5;

    // Active-low segment patterns, decimal point off.
    localparam logic [SEG_W-1:0] SEG_0     = 8'b1100_0000;
    localparam logic [SEG_W-1:0] SEG_1     = 8'b1111_1001;
    localparam logic [SEG_W-1:0] SEG_2     = 8'b1010_0100;
    localparam logic [SEG_W-1:0] SEG_3     = 8'b1011_0000;
    localparam logic [SEG_W-1:0] SEG_4     = 8'b1001_1001;
    localparam logic [SEG_W-1:0] SEG_5     = 8'b1001_0010;
    localparam logic [SEG_W-1:0] SEG_6     = 8'b1000_0010;
    localparam logic [SEG_W-1:0] SEG_7     = 8'b1111_1000;
    localparam logic [SEG_W-1:0] SEG_8     = 8'b1000_0000;
    localparam logic [SEG_W-1:0] SEG_9     = 8'b1001_0000;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'b1111_1111;

    // Partial conversion: BCD digits built so far and binary bits still to shift in.
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } dabble_t;

    // Segment bytes of the four shown digits, index 0 is the units digit.
    typedef logic [SHOW_DIGITS-1:0][SEG_W-1:0] seg_frame_t;

    // One shift-add-3 step: correct every digit of five or more, then shift left.
    function automatic dabble_t dabble_step(input dabble_t d);
        dabble_t                  r;
        logic [BCD_W+BIN_W-1:0] w;
        r = d;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r.bcd[4*i +: 4] >= 4'd5) begin
                r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
            end
        end
        w     = {r.bcd, r.bin} << 1;
        r.bcd = w[BCD_W+BIN_W-1:BIN_W];
        r.bin = w[BIN_W-1:0];
        return r;
    endfunction

    // Decimal digit to active-low segment byte.
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] s;
        case (digit)
            4'd0:    s = SEG_0;
            4'd1:    s = SEG_1;
            4'd2:    s = SEG_2;
            4'd3:    s = SEG_3;
            4'd4:    s = SEG_4;
            4'd5:    s = SEG_5;
            4'd6:    s = SEG_6;
            4'd7:    s = SEG_7;
            4'd8:    s = SEG_8;
            4'd9:    s = SEG_9;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bss_dabble_stage.sv =====
// One register stage of the binary to BCD conversion.
// Runs STEPS shift-add-3 steps on the payload; depends on bss_pkg.
`default_nettype none

module bss_dabble_stage #(
    parameter int STEPS = 5
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bss_pkg::dabble_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bss_pkg::dabble_t     out_data
);
    import bss_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    dabble_t data_reg;
    dabble_t data_next;

    // The stage takes a new item when it is empty or its item moves on.
    assign in_ready = !valid_reg || out_ready;

    // Conversion steps of this stage.
    always_comb begin
        dabble_t x;
        x = in_data;
        for (int i = 0; i < STEPS; i++) begin
            x = dabble_step(x);
        end
        data_next  = x;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    // Valid bit with reset, payload without.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bss_seg_stage.sv =====
// Segment lookup stage: maps the four lower BCD digits to segment bytes.
// The ten-thousands digit is dropped, so the value shows modulo 10000; depends on bss_pkg.
`default_nettype none

module bss_seg_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bss_pkg::dabble_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bss_pkg::seg_frame_t   out_segs
);
    import bss_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    seg_frame_t segs_reg;
    seg_frame_t segs_next;

    assign in_ready = !valid_reg || out_ready;

    // Table lookup for each shown digit.
    always_comb begin
        for (int i = 0; i < SHOW_DIGITS; i++) begin
            segs_next[i] = seg_of(in_data.bcd[4*i +: 4]);
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            segs_reg <= segs_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_segs  = segs_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bss_scan.sv =====
// Scan serializer and output register: sends four frames per value,
// thousands first, units last with tlast set; depends on bss_pkg.
`default_nettype none

module bss_scan (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire bss_pkg::seg_frame_t        in_segs,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [bss_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast
);
    import bss_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    seg_frame_t       segs_reg;
    logic             last;
    logic             load;
    logic [3:0]       anodes;

    assign last = (pos_reg == '0);

    // A new value loads when the register is empty or the units frame leaves.
    assign in_ready = !valid_reg || (m_tready && last);
    assign load     = in_ready && in_valid;

    // Frame position counts down from thousands to units.
    always_comb begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        if (load) begin
            valid_next = 1'b1;
            pos_next   = POS_W'(SHOW_DIGITS - 1);
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                pos_next = pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            segs_reg <= in_segs;
        end
    end

    // Active-low one-hot anode select for the current position.
    assign anodes = ~(4'b0001 << pos_reg);

    assign m_tvalid = valid_reg;
    assign m_tlast  = last;
    assign m_tdata  = {2'b00, pos_reg, anodes, segs_reg[pos_reg]};

endmodule

`default_nettype wire

// ===== rtl/core/bcd_seven_segment_scan_top.sv =====
// Four-digit seven-segment scan: binary value in, four scan frames out.
// An input transfer passes stages 0 to 2, the segment stage and the scan register before its first frame,
// then frames go out one a cycle while m_tready is high; the next value loads as the units frame leaves.
// Conversion runs in three shift-add-3 stages and one segment lookup stage.
// Reset: synchronous active-low aresetn clears all valid bits; payload is not reset.
// Depends on bss_pkg, bss_dabble_stage, bss_seg_stage and bss_scan.
`default_nettype none

module bcd_seven_segment_scan_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: show_value[15:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // m_tdata: segments[7:0], anodes[11:8], digit_position[13:12], zero[15:14]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);
    import bss_pkg::*;

    dabble_t    d0_in;
    dabble_t    d0_out;
    dabble_t    d1_out;
    dabble_t    d2_out;
    seg_frame_t segs;
    logic       v0;
    logic       r0;
    logic       v1;
    logic       r1;
    logic       v2;
    logic       r2;
    logic       v3;
    logic       r3;

    // Conversion starts with empty BCD digits and the full binary value.
    assign d0_in.bcd = '0;
    assign d0_in.bin = s_tdata;

    bss_dabble_stage #(.STEPS(STEPS_S0)) u_stage0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (d0_in),
        .out_valid (v0),
        .out_ready (r0),
        .out_data  (d0_out)
    );

    bss_dabble_stage #(.STEPS(STEPS_S1)) u_stage1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0),
        .in_ready  (r0),
        .in_data   (d0_out),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (d1_out)
    );

    bss_dabble_stage #(.STEPS(STEPS_S2)) u_stage2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1_out),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2_out)
    );

    bss_seg_stage u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (d2_out),
        .out_valid (v3),
        .out_ready (r3),
        .out_segs  (segs)
    );

    bss_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v3),
        .in_ready (r3),
        .in_segs  (segs),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
